FILE: rtl/lzfbd_pkg.sv
// ----------------------------------------------------------------------------
// lzfbd_pkg
// Shared types and constants of the flag-byte LZSS decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lzfbd_pkg;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_ACCEPT,   // take one stream byte
    ST_COPY_RD,  // read one history byte of a back-reference
    ST_COPY_WR,  // emit and write back the byte just read
    ST_END       // give the end-of-stream result and clear the stream state
  } st_t;

  // Result kinds
  typedef enum logic [1:0] {
    STAT_DATA      = 2'd0,
    STAT_END_OK    = 2'd1,
    STAT_END_SHORT = 2'd2,
    STAT_HDR_ERR   = 2'd3
  } stat_t;

  // Parse phases: 0..3 magic, 4..7 size, 8..11 optional pad word
  localparam logic [3:0] PH_MAGIC0 = 4'd0;
  localparam logic [3:0] PH_SIZE3  = 4'd7;
  localparam logic [3:0] PH_PAD0   = 4'd8;
  localparam logic [3:0] PH_PAD1   = 4'd9;
  localparam logic [3:0] PH_PAD2   = 4'd10;
  localparam logic [3:0] PH_PAD3   = 4'd11;
  localparam logic [3:0] PH_DECODE = 4'd12;
  localparam logic [3:0] PH_ERROR  = 4'd15;

  // Flag group exhausted
  localparam logic [3:0] BITPOS_EMPTY = 4'd8;

  // Back-reference format
  localparam logic [7:0] DIST_HI_MASK = 8'hF0;
  localparam logic [7:0] LEN_MASK     = 8'h0F;
  localparam logic [4:0] LEN_BIAS     = 5'd3;
  localparam int unsigned DIST_W      = 13;  // 12-bit field plus one

  // Expected stream magic, first byte first
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'h50;
      2'd1:    val = 8'h53;
      2'd2:    val = 8'h44;
      2'd3:    val = 8'h4B;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lzfbd_ram.sv
// ----------------------------------------------------------------------------
// lzfbd_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lzfbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lzfbd_top_placeholder.sv
// ----------------------------------------------------------------------------
// lzfbd_hdr
// Header and pad-word parser: magic check, declared size and pad skip.
// ----------------------------------------------------------------------------
`default_nettype none

module lzfbd_hdr (
  input  wire logic [3:0]  phase,
  input  wire logic [31:0] target_size,
  input  wire logic        pad_zero,
  input  wire logic [31:0] size_limit,
  input  wire logic [7:0]  in_byte,
  output logic      [3:0]  phase_next,
  output logic      [31:0] target_next,
  output logic             pad_next,
  output logic             load_flags
);

  logic [31:0] size_new;

  always_comb begin
    size_new    = target_size;
    phase_next  = phase;
    target_next = target_size;
    pad_next    = pad_zero;
    load_flags  = 1'b0;
    case (phase[1:0])
      2'd0:    size_new[7:0]   = in_byte;
      2'd1:    size_new[15:8]  = in_byte;
      2'd2:    size_new[23:16] = in_byte;
      2'd3:    size_new[31:24] = in_byte;
      default: size_new        = target_size;
    endcase
    if (phase[3:2] == 2'b00) begin
      // magic bytes
      phase_next = (in_byte == lzfbd_pkg::magic_byte(phase[1:0])) ? phase + 4'd1
                                                                  : lzfbd_pkg::PH_ERROR;
    end else if (phase[3:2] == 2'b01) begin
      // little-endian declared size
      target_next = size_new;
      phase_next  = phase + 4'd1;
      if (phase == lzfbd_pkg::PH_SIZE3 &&
          (size_new == 32'd0 || size_new > size_limit)) begin
        phase_next = lzfbd_pkg::PH_ERROR;
      end
    end else begin
      case (phase)
        lzfbd_pkg::PH_PAD0: begin
          if (in_byte == 8'd0) begin
            pad_next   = 1'b1;
            phase_next = lzfbd_pkg::PH_PAD1;
          end else begin
            load_flags = 1'b1;
            phase_next = lzfbd_pkg::PH_DECODE;
          end
        end
        lzfbd_pkg::PH_PAD1, lzfbd_pkg::PH_PAD2: begin
          if (in_byte != 8'd0) begin
            pad_next = 1'b0;
          end
          phase_next = phase + 4'd1;
        end
        lzfbd_pkg::PH_PAD3: begin
          // a zero flag byte in front would have been an impossible reference
          load_flags = !(pad_zero && in_byte == 8'd0);
          pad_next   = 1'b0;
          phase_next = lzfbd_pkg::PH_DECODE;
        end
        default: phase_next = phase;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lzss_flag_byte_decompressor.sv
// Output: a literal is loaded into the output register at the end of its
//   transaction; the end result is loaded in ST_END, once the output register has room.
// Throughput: header, flag and literal bytes at one per cycle while the output
//   register has room; a back-reference holds input while it copies each byte as a
//   history RAM read in ST_COPY_RD, then emit and write back in ST_COPY_WR.
// Reset: synchronous, clears control state except copy_src; history RAM is not cleared.
// ----------------------------------------------------------------------------
// lzss_flag_byte_decompressor
// Top level: header parse, flag decode, back-reference copy over the history.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_flag_byte_decompressor #(
  parameter int unsigned WINDOW_DEPTH = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // compressed stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tlast,   // in_last
  // decoded results out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [39:0] m_axis_tdata,   // [7:0] out_byte, [39:8] produced
  output logic      [1:0]  m_axis_tuser,   // [1:0] status
  output logic             m_axis_tlast,   // end_mark
  // size_limit register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned DIST_W_L = lzfbd_pkg::DIST_W;

  // sequencer
  lzfbd_pkg::st_t state, state_next;

  // stream state
  logic [31:0] size_limit;
  logic [31:0] out_count, out_count_next;
  logic [31:0] target_size, target_size_next;
  logic [3:0]  phase, phase_next;
  logic [7:0]  flag_bits, flag_bits_next;
  logic [3:0]  bit_pos, bit_pos_next;
  logic [7:0]  first_ref, first_ref_next;
  logic        await_ref, await_ref_next;
  logic        pad_zero, pad_zero_next;
  logic        draining, draining_next;
  logic        end_pending, end_pending_next;

  // copy engine
  logic [AW-1:0] copy_src, copy_src_next;
  logic [4:0]    copy_left, copy_left_next;
  logic          copy_start;
  logic          copy_done;

  // header parser
  logic [3:0]  hdr_phase;
  logic [31:0] hdr_target;
  logic        hdr_pad;
  logic        hdr_load;

  // history RAM
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata, mem_rdata;

  // output register
  logic        out_valid;
  logic [7:0]  out_byte;
  logic [1:0]  out_status;
  logic [31:0] out_produced;
  logic        out_end;
  logic        out_load;
  logic [7:0]  out_byte_d;
  logic [1:0]  out_status_d;
  logic [31:0] out_produced_d;
  logic        out_end_d;

  // datapath helpers
  logic              in_fire, slot_free, emit;
  logic [7:0]        emit_val;
  logic [31:0]       count_inc;
  logic [DIST_W_L-1:0] ref_dist;
  logic              hdr_bad;

  assign in_fire   = s_axis_tvalid & s_axis_tready;
  assign slot_free = !out_valid | m_axis_tready;
  assign count_inc = out_count + 32'd1;
  assign ref_dist  = {1'b0, s_axis_tdata[7:4], first_ref} + DIST_W_L'(1);
  assign hdr_bad   = (phase < lzfbd_pkg::PH_PAD0) || (phase == lzfbd_pkg::PH_ERROR);

  lzfbd_hdr u_hdr (
    .phase       (phase),
    .target_size (target_size),
    .pad_zero    (pad_zero),
    .size_limit  (size_limit),
    .in_byte     (s_axis_tdata),
    .phase_next  (hdr_phase),
    .target_next (hdr_target),
    .pad_next    (hdr_pad),
    .load_flags  (hdr_load)
  );

  lzfbd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (copy_src),
    .rdata (mem_rdata)
  );

  // --------------------------------------------------------------------------
  // Datapath: one stream byte per transaction in ST_ACCEPT, one copied byte
  // per pass through ST_COPY_RD / ST_COPY_WR.
  // --------------------------------------------------------------------------
  always_comb begin
    out_count_next   = out_count;
    target_size_next = target_size;
    phase_next       = phase;
    flag_bits_next   = flag_bits;
    bit_pos_next     = bit_pos;
    first_ref_next   = first_ref;
    await_ref_next   = await_ref;
    pad_zero_next    = pad_zero;
    draining_next    = draining;
    end_pending_next = end_pending;
    copy_src_next    = copy_src;
    copy_left_next   = copy_left;
    copy_start       = 1'b0;
    copy_done        = 1'b0;
    emit             = 1'b0;
    emit_val         = s_axis_tdata;
    mem_re           = 1'b0;
    out_load         = 1'b0;
    out_byte_d       = 8'd0;
    out_status_d     = lzfbd_pkg::STAT_DATA;
    out_produced_d   = 32'd0;
    out_end_d        = 1'b0;

    case (state)
      lzfbd_pkg::ST_ACCEPT: begin
        if (in_fire) begin
          end_pending_next = s_axis_tlast;
          if (phase < lzfbd_pkg::PH_DECODE) begin
            phase_next       = hdr_phase;
            target_size_next = hdr_target;
            pad_zero_next    = hdr_pad;
            if (hdr_load) begin
              flag_bits_next = s_axis_tdata;
              bit_pos_next   = 4'd0;
            end
          end else if (phase == lzfbd_pkg::PH_DECODE && !draining) begin
            if (await_ref) begin
              await_ref_next = 1'b0;
              if (32'(ref_dist) > out_count) begin
                // reference before the start: drop rest of flag group
                bit_pos_next = lzfbd_pkg::BITPOS_EMPTY;
              end else begin
                copy_start     = 1'b1;
                copy_src_next  = AW'(out_count - 32'(ref_dist));
                copy_left_next = 5'(s_axis_tdata & lzfbd_pkg::LEN_MASK) + lzfbd_pkg::LEN_BIAS;
              end
            end else if (bit_pos[3]) begin
              flag_bits_next = s_axis_tdata;
              bit_pos_next   = 4'd0;
            end else begin
              bit_pos_next = bit_pos + 4'd1;
              if (flag_bits[bit_pos[2:0]]) begin
                emit = 1'b1;
              end else begin
                first_ref_next = s_axis_tdata;
                await_ref_next = 1'b1;
              end
            end
          end
        end
      end

      lzfbd_pkg::ST_COPY_RD: begin
        mem_re = 1'b1;
      end

      lzfbd_pkg::ST_COPY_WR: begin
        if (slot_free) begin
          emit           = 1'b1;
          emit_val       = mem_rdata;
          copy_src_next  = copy_src + AW'(1);
          copy_left_next = copy_left - 5'd1;
          copy_done      = (copy_left == 5'd1) || (count_inc >= target_size);
        end
      end

      lzfbd_pkg::ST_END: begin
        if (slot_free) begin
          out_load  = 1'b1;
          out_end_d = 1'b1;
          if (hdr_bad) begin
            out_status_d = lzfbd_pkg::STAT_HDR_ERR;
          end else if (out_count >= target_size) begin
            out_status_d   = lzfbd_pkg::STAT_END_OK;
            out_produced_d = out_count;
          end else begin
            out_status_d   = lzfbd_pkg::STAT_END_SHORT;
            out_produced_d = out_count;
          end
          // back to the state of a fresh stream
          out_count_next   = 32'd0;
          target_size_next = 32'd0;
          phase_next       = lzfbd_pkg::PH_MAGIC0;
          flag_bits_next   = 8'd0;
          bit_pos_next     = lzfbd_pkg::BITPOS_EMPTY;
          first_ref_next   = 8'd0;
          await_ref_next   = 1'b0;
          pad_zero_next    = 1'b0;
          draining_next    = 1'b0;
          end_pending_next = 1'b0;
        end
      end

      default: begin
        mem_re = 1'b0;
      end
    endcase

    // a produced byte: record in history, count, and present it
    if (emit) begin
      out_count_next = count_inc;
      out_load       = 1'b1;
      out_byte_d     = emit_val;
      out_status_d   = lzfbd_pkg::STAT_DATA;
      out_produced_d = count_inc;
      out_end_d      = 1'b0;
      if (count_inc >= target_size) begin
        draining_next = 1'b1;
      end
    end
  end

  assign mem_we    = emit;
  assign mem_waddr = out_count[AW-1:0];
  assign mem_wdata = emit_val;

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      lzfbd_pkg::ST_ACCEPT: begin
        if (in_fire) begin
          if (copy_start) begin
            state_next = lzfbd_pkg::ST_COPY_RD;
          end else if (s_axis_tlast) begin
            state_next = lzfbd_pkg::ST_END;
          end
        end
      end
      lzfbd_pkg::ST_COPY_RD: begin
        state_next = lzfbd_pkg::ST_COPY_WR;
      end
      lzfbd_pkg::ST_COPY_WR: begin
        if (slot_free) begin
          if (!copy_done) begin
            state_next = lzfbd_pkg::ST_COPY_RD;
          end else if (end_pending) begin
            state_next = lzfbd_pkg::ST_END;
          end else begin
            state_next = lzfbd_pkg::ST_ACCEPT;
          end
        end
      end
      lzfbd_pkg::ST_END: begin
        if (slot_free) begin
          state_next = lzfbd_pkg::ST_ACCEPT;
        end
      end
      default: state_next = lzfbd_pkg::ST_ACCEPT;
    endcase
  end

  // Sequencer: handshake outputs. Take a byte only when a result it may cause
  // has room in the output register.
  always_comb begin
    case (state)
      lzfbd_pkg::ST_ACCEPT: s_axis_tready = slot_free;
      default:              s_axis_tready = 1'b0;
    endcase
    cfg_ready = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lzfbd_pkg::ST_ACCEPT;
      size_limit  <= 32'hFFFF_FFFF;
      out_count   <= 32'd0;
      target_size <= 32'd0;
      phase       <= lzfbd_pkg::PH_MAGIC0;
      flag_bits   <= 8'd0;
      bit_pos     <= lzfbd_pkg::BITPOS_EMPTY;
      first_ref   <= 8'd0;
      await_ref   <= 1'b0;
      pad_zero    <= 1'b0;
      draining    <= 1'b0;
      end_pending <= 1'b0;
      copy_left   <= 5'd0;
    end else begin
      state       <= state_next;
      out_count   <= out_count_next;
      target_size <= target_size_next;
      phase       <= phase_next;
      flag_bits   <= flag_bits_next;
      bit_pos     <= bit_pos_next;
      first_ref   <= first_ref_next;
      await_ref   <= await_ref_next;
      pad_zero    <= pad_zero_next;
      draining    <= draining_next;
      end_pending <= end_pending_next;
      copy_left   <= copy_left_next;
      if (cfg_valid && cfg_ready) begin
        size_limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    copy_src <= copy_src_next;
  end

  // output register: hold until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte     <= out_byte_d;
      out_status   <= out_status_d;
      out_produced <= out_produced_d;
      out_end      <= out_end_d;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_produced, out_byte};
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_end;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (phase == lzfbd_pkg::PH_DECODE) |-> (out_count <= target_size))
    else $error("output count passed the declared size");

  a_ram_ports: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("history read and write in the same cycle");

  a_copy_len: assert property (@(posedge clk) disable iff (rst)
    (state == lzfbd_pkg::ST_COPY_RD || state == lzfbd_pkg::ST_COPY_WR)
      |-> (copy_left != 5'd0))
    else $error("copy running with no bytes left");

  a_stream_clear: assert property (@(posedge clk) disable iff (rst)
    (state == lzfbd_pkg::ST_END && slot_free)
      |=> (out_count == 32'd0 && phase == lzfbd_pkg::PH_MAGIC0 && m_axis_tlast))
    else $error("stream state not cleared after end result");

endmodule

`default_nettype wire
